/* hw/rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; define NO_ASSERTIONS to drop them.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset.
`define KEQ_ASSERT(name, clock, rstn, prop, msg) \
	name: assert property (@(posedge clock) disable iff (!(rstn)) (prop)) \
		else $error(msg);
// Check a property on every clock edge, reset included.
`define KEQ_ASSERT_ALWAYS(name, clock, prop, msg) \
	name: assert property (@(posedge clock) (prop)) else $error(msg);
`else
`define KEQ_ASSERT(name, clock, rstn, prop, msg)
`define KEQ_ASSERT_ALWAYS(name, clock, prop, msg)
`endif

`endif

/* hw/rtl/keq_pkg.sv */
// ---------------------------------------------------------------------------
// keq_pkg
// Command, event and key codes of the key event queue.
// ---------------------------------------------------------------------------
package keq_pkg;

	localparam int unsigned KEY_W      = 10;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 8;
	localparam int unsigned SUM_W      = 9;

	typedef enum logic [1:0] {
		CMD_EVENT  = 2'd0,
		CMD_RESULT = 2'd1,
		CMD_POP    = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		RES_NA    = 2'd0,
		RES_FAIL  = 2'd1,
		RES_PASS  = 2'd2,
		RES_OTHER = 2'd3
	} result_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_THRESHOLD = 1'b0,
		CFG_REMAP     = 1'b1
	} cfg_idx_t;

	// Input event types and axes
	localparam logic [4:0]  EV_SYN = 5'd0;
	localparam logic [4:0]  EV_KEY = 5'd1;
	localparam logic [4:0]  EV_REL = 5'd2;
	localparam logic [15:0] REL_Y  = 16'd1;
	localparam logic [15:0] KC_LIMIT = 16'd767;

	// Key codes
	localparam logic [KEY_W-1:0] KC_DOWN      = 10'd108;
	localparam logic [KEY_W-1:0] KC_UP        = 10'd103;
	localparam logic [KEY_W-1:0] KC_BACK      = 10'd158;
	localparam logic [KEY_W-1:0] KC_POWER     = 10'd116;
	localparam logic [KEY_W-1:0] KC_VOLDOWN   = 10'd114;
	localparam logic [KEY_W-1:0] KC_VOLUP     = 10'd115;
	localparam logic [KEY_W-1:0] KC_ALT_UP    = 10'd139;

	localparam logic [CFG_DATA_W-1:0] THRESHOLD_RST = 8'd3;

	// Map the alternate up and back codes onto the volume keys.
	function automatic logic [KEY_W-1:0] remap_key(input logic [KEY_W-1:0] code,
			input logic enable);
		logic [KEY_W-1:0] res;
		res = code;
		if (enable) begin
			if (code == KC_ALT_UP) begin
				res = KC_VOLUP;
			end else if (code == KC_BACK) begin
				res = KC_VOLDOWN;
			end
		end
		return res;
	endfunction

endpackage

/* hw/rtl/keq_ram.sv */
// ---------------------------------------------------------------------------
// keq_ram
// Simple dual-port key store: one write port, one registered read port.
// ---------------------------------------------------------------------------
module keq_ram #(
	parameter int unsigned DEPTH = 256,
	parameter int unsigned WIDTH = 10
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write one entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read one entry; hold the data until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* hw/rtl/key_event_queue_core.sv */
// ---------------------------------------------------------------------------
// key_event_queue_core
// Key FIFO fed by raw input events and test results, with trackball
// threshold logic that turns vertical motion into fake up/down keys.
// ---------------------------------------------------------------------------
// The block takes one command beat per cycle and returns exactly one result
// beat for it. The result passes through stage 1 and the output register
// before it is presented on the outputs: the command updates the queue
// pointers, the count and the motion sum in the cycle it is accepted, a pop
// reads the key store (a synchronous memory of QUEUE_DEPTH entries) in that
// same cycle, and the read data meets the rest of the result in the output
// register. While the result side keeps taking beats the input never stalls;
// when a result waits, one more command beat is taken and then the input
// stalls until the result side moves again. Pops and pushes never touch the
// store in the same cycle, so no forwarding is needed. The key store has no
// reset; only entries already written are read.
`include "assert_macros.svh"

module key_event_queue_core #(
	parameter int unsigned QUEUE_DEPTH = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// command channel
	input  logic                                evt_valid,
	output logic                                evt_stall,
	input  logic [1:0]                          command,
	input  logic [4:0]                          event_type,
	input  logic [15:0]                         event_code,
	input  logic signed [31:0]                  event_value,
	input  logic [1:0]                          result_code,
	// result channel
	output logic                                res_valid,
	input  logic                                res_stall,
	output logic                                key_valid,
	output logic [keq_pkg::KEY_W-1:0]           pop_code,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0]    queue_level,
	output logic                                dropped,
	// configuration channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [keq_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [keq_pkg::CFG_DATA_W-1:0]      cfg_data
);

	import keq_pkg::*;

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned RING_W = CNT_W + 1;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	// Configuration registers
	logic [CFG_DATA_W-1:0] thr_q;
	logic                  remap_q;

	// Queue and motion state
	logic [PTR_W-1:0]        rd_ptr_q, wr_ptr_q;
	logic [CNT_W-1:0]        cnt_q;
	logic signed [SUM_W-1:0] sum_q;

	// Pipeline: stage 1 waits for the store read, then the output register
	logic             valid_s1, key_valid_s1, dropped_s1;
	logic [CNT_W-1:0] level_s1;
	logic             out_valid_q, key_valid_q, dropped_q;
	logic [KEY_W-1:0] pop_code_q;
	logic [CNT_W-1:0] level_q;

	logic             accept, adv_s1;
	logic             push_req, do_push, do_pop, do_clear, full, drop;
	logic [KEY_W-1:0] push_code;
	logic             sum_load;
	logic signed [SUM_W-1:0] sum_nxt;
	logic signed [32:0] sum_add, thr_pos, thr_neg;
	logic [CNT_W-1:0] cnt_nxt;
	logic [KEY_W-1:0] rd_data;

	// Handshakes
	assign adv_s1    = !out_valid_q || !res_stall;
	assign evt_stall = valid_s1 && !adv_s1;
	assign accept    = evt_valid && !evt_stall;
	assign cfg_ready = 1'b1;

	// Decode the command and work out the queue and motion updates
	always_comb begin
		push_req  = 1'b0;
		push_code = KC_BACK;
		do_pop    = 1'b0;
		do_clear  = 1'b0;
		sum_load  = 1'b0;
		sum_nxt   = sum_q;
		thr_pos   = $signed({25'd0, thr_q});
		thr_neg   = -thr_pos;
		sum_add   = $signed({{(33 - SUM_W){sum_q[SUM_W-1]}}, sum_q})
			+ $signed({event_value[31], event_value});
		full      = (cnt_q == CNT_FULL);
		unique case (cmd_t'(command))
			CMD_EVENT: begin
				if (event_type == EV_SYN) begin
					// sync: no change
				end else if (event_type == EV_REL) begin
					if (event_code == REL_Y) begin
						sum_load = 1'b1;
						if (sum_add > thr_pos) begin
							sum_nxt   = '0;
							push_req  = 1'b1;
							push_code = KC_DOWN;
						end else if (sum_add < thr_neg) begin
							sum_nxt   = '0;
							push_req  = 1'b1;
							push_code = KC_UP;
						end else begin
							sum_nxt = sum_add[SUM_W-1:0];
						end
					end
				end else begin
					sum_load = 1'b1;
					sum_nxt  = '0;
					if (event_type == EV_KEY && event_code <= KC_LIMIT
							&& !event_value[31] && (|event_value)) begin
						push_req  = 1'b1;
						push_code = event_code[KEY_W-1:0];
					end
				end
			end
			CMD_RESULT: begin
				case (result_t'(result_code))
					RES_NA: begin
						push_req  = 1'b1;
						push_code = KC_BACK;
					end
					RES_FAIL: begin
						push_req  = 1'b1;
						push_code = KC_POWER;
					end
					RES_PASS: begin
						push_req  = 1'b1;
						push_code = KC_VOLDOWN;
					end
					default: begin
						push_req = 1'b0;
					end
				endcase
			end
			CMD_POP: begin
				do_pop = (cnt_q != '0);
			end
			CMD_CLEAR: begin
				do_clear = 1'b1;
			end
			default: begin
				do_clear = 1'b0;
			end
		endcase
		do_push = push_req && !full;
		drop    = push_req && full;
		if (do_clear) begin
			cnt_nxt = '0;
		end else if (do_push) begin
			cnt_nxt = cnt_q + 1'b1;
		end else if (do_pop) begin
			cnt_nxt = cnt_q - 1'b1;
		end else begin
			cnt_nxt = cnt_q;
		end
	end

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= THRESHOLD_RST;
			remap_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_THRESHOLD: thr_q   <= cfg_data;
				CFG_REMAP:     remap_q <= cfg_data[0];
				default:       thr_q   <= thr_q;
			endcase
		end
	end

	// Advance pointers, count and motion sum on an accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			cnt_q    <= '0;
			sum_q    <= '0;
		end else if (accept) begin
			cnt_q <= cnt_nxt;
			if (sum_load) begin
				sum_q <= sum_nxt;
			end
			if (do_clear) begin
				rd_ptr_q <= '0;
				wr_ptr_q <= '0;
			end else begin
				if (do_push) begin
					wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
				end
				if (do_pop) begin
					rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
				end
			end
		end
	end

	// Key store
	keq_ram #(
		.DEPTH (QUEUE_DEPTH),
		.WIDTH (KEY_W)
	) u_store (
		.clk     (clk),
		.wr_en   (accept && do_push),
		.wr_addr (wr_ptr_q),
		.wr_data (push_code),
		.rd_en   (accept && do_pop),
		.rd_addr (rd_ptr_q),
		.rd_data (rd_data)
	);

	// Stage 1: hold the result while the store read completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_valid_s1 <= do_pop;
			dropped_s1   <= drop;
			level_s1     <= cnt_nxt;
		end
	end

	// Output register: load the finished result, drop it when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			key_valid_q <= key_valid_s1;
			pop_code_q  <= key_valid_s1 ? remap_key(rd_data, remap_q) : '0;
			level_q     <= level_s1;
			dropped_q   <= dropped_s1;
		end
	end

	assign res_valid   = out_valid_q;
	assign key_valid   = key_valid_q;
	assign pop_code    = pop_code_q;
	assign queue_level = level_q;
	assign dropped     = dropped_q;

	// Checks
	`KEQ_ASSERT(a_cnt_bound, clk, arst_n, cnt_q <= CNT_FULL, "entry count beyond depth")
	`KEQ_ASSERT(a_ring_ptrs, clk, arst_n, (RING_W'(rd_ptr_q) + RING_W'(cnt_q) == RING_W'(wr_ptr_q)) || (RING_W'(rd_ptr_q) + RING_W'(cnt_q) == RING_W'(wr_ptr_q) + RING_W'(QUEUE_DEPTH)), "write pointer out of step with read pointer and count")
	`KEQ_ASSERT(a_drop_full, clk, arst_n, (out_valid_q && dropped_q) |-> (level_q == CNT_FULL && !key_valid_q), "drop reported without a full queue")
	`KEQ_ASSERT(a_no_key_zero, clk, arst_n, (out_valid_q && !key_valid_q) |-> (pop_code_q == '0), "key code set without a popped key")
	`KEQ_ASSERT(a_s1_hold, clk, arst_n, (valid_s1 && !adv_s1) |=> (valid_s1 && $stable(level_s1) && $stable(rd_data)), "stage 1 changed while stalled")

endmodule

/* tb/key_event_queue_checker.sv */
// ---------------------------------------------------------------------------
// key_event_queue_checker
// Watches the command, result and configuration channels of the key event
// queue, predicts every result beat and compares it field by field.
// ---------------------------------------------------------------------------
module key_event_queue_checker #(
	parameter int unsigned QUEUE_DEPTH = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                evt_valid,
	input  logic                                evt_stall,
	input  logic [1:0]                          command,
	input  logic [4:0]                          event_type,
	input  logic [15:0]                         event_code,
	input  logic signed [31:0]                  event_value,
	input  logic [1:0]                          result_code,
	input  logic                                res_valid,
	input  logic                                res_stall,
	input  logic                                key_valid,
	input  logic [keq_pkg::KEY_W-1:0]           pop_code,
	input  logic [$clog2(QUEUE_DEPTH+1)-1:0]    queue_level,
	input  logic                                dropped,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic [keq_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [keq_pkg::CFG_DATA_W-1:0]      cfg_data,
	output int                                  error_count,
	output int                                  results_checked
);

	import keq_pkg::*;

	localparam int LEVEL_W = $clog2(QUEUE_DEPTH+1);

	typedef struct {
		logic               key_valid;
		logic [KEY_W-1:0]   pop_code;
		logic [LEVEL_W-1:0] level;
		logic               dropped;
	} key_result_t;

	key_result_t awaited_results[$];
	key_result_t predicted;
	key_result_t oldest;

	// Own copy of the queue, the motion sum and the registers
	logic [KEY_W-1:0]      key_ring [QUEUE_DEPTH];
	int unsigned           ring_head;
	int unsigned           ring_count;
	logic signed [32:0]    motion_acc;
	logic [CFG_DATA_W-1:0] motion_limit;
	logic                  remap_on;

	// Print one line for a mismatch and count it.
	task automatic report_mismatch(input string field, input int got, input int want);
		error_count++;
		$display("checker: %s mismatch at result beat %0d: got %0d, expected %0d",
			field, results_checked, got, want);
	endtask

	// Append a code; return 1 when the queue has no room left.
	function automatic logic push_key(input logic [KEY_W-1:0] code);
		int unsigned slot;
		if (ring_count >= QUEUE_DEPTH) begin
			return 1'b1;
		end
		slot = (ring_head + ring_count) % QUEUE_DEPTH;
		key_ring[slot] = code;
		ring_count++;
		return 1'b0;
	endfunction

	// Apply one command beat to the predicted state and build its result.
	task automatic step_queue(output key_result_t res);
		logic signed [32:0] band;
		logic [KEY_W-1:0]   popped;
		band = $signed({25'd0, motion_limit});
		res.key_valid = 1'b0;
		res.pop_code  = '0;
		res.dropped   = 1'b0;
		case (cmd_t'(command))
			CMD_EVENT: begin
				if (event_type == EV_SYN) begin
					// sync: leave everything as it is
				end else if (event_type == EV_REL) begin
					// sum vertical motion only; other axes keep the sum
					if (event_code == REL_Y) begin
						motion_acc = motion_acc + $signed({event_value[31], event_value});
						if (motion_acc > band) begin
							motion_acc  = '0;
							res.dropped = push_key(KC_DOWN);
						end else if (motion_acc < -band) begin
							motion_acc  = '0;
							res.dropped = push_key(KC_UP);
						end
					end
				end else begin
					motion_acc = '0;
					if (event_type == EV_KEY && event_code <= KC_LIMIT && event_value > 0) begin
						res.dropped = push_key(event_code[KEY_W-1:0]);
					end
				end
			end
			CMD_RESULT: begin
				case (result_t'(result_code))
					RES_NA:   res.dropped = push_key(KC_BACK);
					RES_FAIL: res.dropped = push_key(KC_POWER);
					RES_PASS: res.dropped = push_key(KC_VOLDOWN);
					default: ;
				endcase
			end
			CMD_POP: begin
				if (ring_count != 0) begin
					popped     = key_ring[ring_head];
					ring_head  = (ring_head + 1) % QUEUE_DEPTH;
					ring_count--;
					if (remap_on && popped == KC_ALT_UP) begin
						popped = KC_VOLUP;
					end else if (remap_on && popped == KC_BACK) begin
						popped = KC_VOLDOWN;
					end
					res.key_valid = 1'b1;
					res.pop_code  = popped;
				end
			end
			CMD_CLEAR: begin
				ring_count = 0;
				ring_head  = 0;
			end
		endcase
		res.level = ring_count[LEVEL_W-1:0];
	endtask

	// Track register writes, predict on command beats, compare result beats.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_head    = 0;
			ring_count   = 0;
			motion_acc   = '0;
			motion_limit = THRESHOLD_RST;
			remap_on     = 1'b0;
			error_count  = 0;
			awaited_results.delete();
			results_checked <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_THRESHOLD: motion_limit = cfg_data;
					CFG_REMAP:     remap_on = cfg_data[0];
				endcase
			end
			if (res_valid && !res_stall) begin
				if (awaited_results.size() == 0) begin
					report_mismatch("unrequested result", 1, 0);
				end else begin
					oldest = awaited_results.pop_front();
					if (key_valid !== oldest.key_valid) begin
						report_mismatch("key_valid", key_valid, oldest.key_valid);
					end
					if (pop_code !== oldest.pop_code) begin
						report_mismatch("pop_code", pop_code, oldest.pop_code);
					end
					if (queue_level !== oldest.level) begin
						report_mismatch("queue_level", queue_level, oldest.level);
					end
					if (dropped !== oldest.dropped) begin
						report_mismatch("dropped", dropped, oldest.dropped);
					end
				end
				results_checked <= results_checked + 1;
			end
			if (evt_valid && !evt_stall) begin
				step_queue(predicted);
				awaited_results.push_back(predicted);
			end
		end
	end

endmodule

/* tb/testbench.sv */
// ---------------------------------------------------------------------------
// testbench
// Drives directed and random command beats into the key event queue under
// several idle and stall mixes, with a long result hold-off and a queue
// overflow pass; the checker module predicts and compares every result.
// ---------------------------------------------------------------------------
module testbench;

	import keq_pkg::*;

	localparam int unsigned QUEUE_DEPTH = 256;
	localparam int LEVEL_W      = $clog2(QUEUE_DEPTH+1);
	localparam int QUIET_LIMIT  = 2000;
	localparam int HOLD_CYCLES  = 300;
	localparam int PHASE_ITEMS  = 40;

	logic                  clk;
	logic                  arst_n;
	logic                  evt_valid;
	logic                  evt_stall;
	logic [1:0]            command;
	logic [4:0]            event_type;
	logic [15:0]           event_code;
	logic signed [31:0]    event_value;
	logic [1:0]            result_code;
	logic                  res_valid;
	logic                  res_stall;
	logic                  key_valid;
	logic [KEY_W-1:0]      pop_code;
	logic [LEVEL_W-1:0]    queue_level;
	logic                  dropped;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int error_count;
	int results_checked;
	int items_sent;
	int sender_idle_pct;
	int sink_stall_pct;
	int hold_request;
	int quiet_cycles;
	int motion_span;

	key_event_queue_core #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.evt_valid(evt_valid),
		.evt_stall(evt_stall),
		.command(command),
		.event_type(event_type),
		.event_code(event_code),
		.event_value(event_value),
		.result_code(result_code),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.key_valid(key_valid),
		.pop_code(pop_code),
		.queue_level(queue_level),
		.dropped(dropped),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	key_event_queue_checker #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) queue_check (
		.clk(clk),
		.arst_n(arst_n),
		.evt_valid(evt_valid),
		.evt_stall(evt_stall),
		.command(command),
		.event_type(event_type),
		.event_code(event_code),
		.event_value(event_value),
		.result_code(result_code),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.key_valid(key_valid),
		.pop_code(pop_code),
		.queue_level(queue_level),
		.dropped(dropped),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.error_count(error_count),
		.results_checked(results_checked)
	);

	// Free-running clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Stall the result side at random; hold off for a long stretch on request.
	initial begin
		res_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				res_stall <= 1'b1;
				repeat (hold_request) @(posedge clk);
				hold_request = 0;
			end else begin
				res_stall <= ($urandom_range(99) < sink_stall_pct);
			end
		end
	end

	// End the run when no beat moves on any channel for too long.
	always @(posedge clk) begin
		if ((evt_valid && !evt_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Offer one command beat, after random idle cycles, and hold it until taken.
	task automatic send_command(input cmd_t cmd, input logic [4:0] etype,
			input logic [15:0] ecode, input logic [31:0] evalue, input logic [1:0] rcode);
		while ($urandom_range(99) < sender_idle_pct) begin
			evt_valid <= 1'b0;
			@(posedge clk);
		end
		evt_valid   <= 1'b1;
		command     <= cmd;
		event_type  <= etype;
		event_code  <= ecode;
		event_value <= evalue;
		result_code <= rcode;
		@(posedge clk);
		while (evt_stall) @(posedge clk);
		items_sent++;
	endtask

	task automatic send_event(input logic [4:0] etype, input logic [15:0] ecode,
			input logic [31:0] evalue);
		send_command(CMD_EVENT, etype, ecode, evalue, 2'($urandom_range(3)));
	endtask

	task automatic send_result(input result_t rcode);
		send_command(CMD_RESULT, 5'($urandom_range(31)), 16'($urandom_range(65535)),
			$urandom, rcode);
	endtask

	task automatic send_pop;
		send_command(CMD_POP, 5'($urandom_range(31)), 16'($urandom_range(65535)), $urandom,
			2'($urandom_range(3)));
	endtask

	task automatic send_clear;
		send_command(CMD_CLEAR, 5'($urandom_range(31)), 16'($urandom_range(65535)), $urandom,
			2'($urandom_range(3)));
	endtask

	// Drop valid and wait until every command beat has its result back.
	task automatic wait_drained;
		evt_valid <= 1'b0;
		@(posedge clk);
		while (results_checked != items_sent) @(posedge clk);
	endtask

	// Offer one register write; valid is lowered by the caller.
	task automatic write_register(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// Write both registers on an idle block.
	task automatic configure(input logic [CFG_DATA_W-1:0] limit, input logic remap);
		wait_drained;
		write_register(CFG_THRESHOLD, limit);
		write_register(CFG_REMAP, {7'($urandom_range(127)), remap});
		cfg_valid <= 1'b0;
		motion_span = int'(limit) + 2;
	endtask

	// One random beat: mostly well-formed motion, keys, results and pops.
	task automatic random_item;
		int unsigned pick;
		logic [15:0] code;
		pick = $urandom_range(99);
		if (pick < 30) begin
			send_event(EV_REL, REL_Y, $urandom_range(2 * motion_span) - motion_span);
		end else if (pick < 34) begin
			send_event(EV_REL, 16'($urandom_range(65535)), $urandom);
		end else if (pick < 50) begin
			case ($urandom_range(3))
				0: code = 16'(KC_ALT_UP);
				1: code = 16'(KC_BACK);
				default: code = 16'($urandom_range(KC_LIMIT));
			endcase
			send_event(EV_KEY, code, $urandom_range(1, 3));
		end else if (pick < 55) begin
			send_event(EV_KEY, 16'($urandom_range(65535)), $urandom);
		end else if (pick < 70) begin
			send_result(result_t'($urandom_range(3)));
		end else if (pick < 95) begin
			send_pop;
		end else if (pick < 97) begin
			send_clear;
		end else begin
			send_event(5'($urandom_range(31)), 16'($urandom_range(65535)), $urandom);
		end
	endtask

	initial begin
		int thresholds [4];
		int idle_mix [4];
		int stall_mix [4];
		arst_n          = 1'b0;
		evt_valid       = 1'b0;
		command         = CMD_EVENT;
		event_type      = EV_SYN;
		event_code      = '0;
		event_value     = '0;
		result_code     = RES_NA;
		cfg_valid       = 1'b0;
		cfg_index       = CFG_THRESHOLD;
		cfg_data        = '0;
		items_sent      = 0;
		sender_idle_pct = 0;
		sink_stall_pct  = 0;
		hold_request    = 0;
		quiet_cycles    = 0;
		motion_span     = int'(THRESHOLD_RST) + 2;
		thresholds      = '{0, 255, $urandom_range(1, 254), 1};
		idle_mix        = '{0, 81, 0, 10};
		stall_mix       = '{0, 0, 81, 10};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed beats at reset settings (band of three)
		send_event(EV_SYN, 16'hFFFF, 32'h7FFF_FFFF);
		send_pop;
		send_event(EV_REL, REL_Y, 32'd2);
		send_event(EV_REL, REL_Y, 32'd2);
		send_event(EV_REL, REL_Y, -32'sd4);
		send_event(EV_REL, REL_Y, 32'd3);
		send_event(EV_REL, 16'd0, 32'h8000_0000);
		send_event(EV_REL, REL_Y, 32'd1);
		send_event(EV_REL, REL_Y, 32'h7FFF_FFFF);
		send_event(EV_REL, REL_Y, 32'h8000_0000);
		send_event(EV_REL, REL_Y, 32'd3);
		send_event(5'd31, REL_Y, 32'd5);
		send_event(EV_REL, REL_Y, 32'd1);
		send_event(EV_KEY, KC_LIMIT, 32'd1);
		send_event(EV_KEY, KC_LIMIT + 16'd1, 32'd1);
		send_event(EV_KEY, 16'd0, 32'h7FFF_FFFF);
		send_event(EV_KEY, 16'd30, 32'd0);
		send_event(EV_KEY, 16'd30, 32'hFFFF_FFFF);
		send_result(RES_NA);
		send_result(RES_FAIL);
		send_result(RES_PASS);
		send_result(RES_OTHER);
		send_pop;
		send_clear;
		send_pop;

		// Overflow pass: fill, drop, wrap the ring and drain it with remap on
		configure(8'd0, 1'b1);
		sender_idle_pct = 10;
		sink_stall_pct  = 10;
		repeat (QUEUE_DEPTH) send_result(result_t'($urandom_range(2)));
		send_result(RES_NA);
		send_event(EV_REL, REL_Y, 32'd1);
		send_event(EV_KEY, 16'd5, 32'd1);
		repeat (5) send_pop;
		repeat (7) send_event(EV_KEY, 16'(KC_ALT_UP), 32'd1);
		repeat (QUEUE_DEPTH + 2) send_pop;

		// Random phases under different idle and stall mixes
		for (int phase = 0; phase < 4; phase++) begin
			configure(8'(thresholds[phase]), phase[0] ^ 1'b1);
			sender_idle_pct = idle_mix[phase];
			sink_stall_pct  = stall_mix[phase];
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (phase == 0 && i == PHASE_ITEMS / 2) begin
					hold_request = HOLD_CYCLES;
				end
				random_item;
			end
		end

		wait_drained;
		repeat (8) @(posedge clk);
		if (error_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
